// ----- rtl/lmeb_pkg.sv -----
// Shared types and constants of the list-mode event builder.
// Used by every module under rtl/.
package lmeb_pkg;

	// Field widths
	localparam int STAMP_W  = 48;
	localparam int WINDOW_W = 28;
	localparam int ENERGY_W = 16;
	localparam int TIME_W   = 64;
	localparam int SLOTS    = 8;

	// Default depth of the front-to-back queue
	localparam int QUEUE_DEPTH = 4;

	// Register reset value
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 28'd90;

	// Word decoding
	localparam logic [31:0] FILL_WORD    = 32'h5e5e5e5e;
	localparam logic [31:0] FILL_ONES    = 32'hffffffff;
	localparam logic [1:0]  TYPE_DATA    = 2'b11;
	localparam logic [31:0] SYNC_MASK    = 32'hc0f00000;
	localparam logic [31:0] SYNC_CODE    = 32'h80400000;
	localparam logic [6:0]  EXCLUDED_CARD = 7'd99;
	localparam logic [31:0] WRAP_LIMIT   = 32'h0000001a;
	localparam logic [2:0]  COARSE_BAD   = 3'd7;

	// Channel idents that are kept
	localparam logic [11:0] ID_SLOW_E0 = 12'd64;
	localparam logic [11:0] ID_SLOW_E1 = 12'd65;
	localparam logic [11:0] ID_FAST_E0 = 12'd72;
	localparam logic [11:0] ID_FAST_E1 = 12'd73;
	localparam logic [11:0] ID_SLOW_T0 = 12'd80;
	localparam logic [11:0] ID_SLOW_T1 = 12'd81;
	localparam logic [11:0] ID_FAST_T0 = 12'd88;
	localparam logic [11:0] ID_FAST_T1 = 12'd89;

	// Slot codes, same order as hit_mask bits
	localparam logic [2:0] SLOT_SLOW_E0 = 3'd0;
	localparam logic [2:0] SLOT_SLOW_E1 = 3'd1;
	localparam logic [2:0] SLOT_FAST_E0 = 3'd2;
	localparam logic [2:0] SLOT_FAST_E1 = 3'd3;
	localparam logic [2:0] SLOT_SLOW_T0 = 3'd4;
	localparam logic [2:0] SLOT_SLOW_T1 = 3'd5;
	localparam logic [2:0] SLOT_FAST_T0 = 3'd6;
	localparam logic [2:0] SLOT_FAST_T1 = 3'd7;

	// One classified data word, front to back
	typedef struct packed {
		logic                close;  // emit open event before the hit
		logic                hit;    // store value into slot
		logic [2:0]          slot;
		logic [15:0]         value;
		logic [STAMP_W-1:0]  stamp;
	} lmeb_op_t;

endpackage

// ----- rtl/lmeb_in_if.sv -----
// Input word channel: valid/ready plus the two 32-bit list-mode halves.
// Depends on nothing.
interface lmeb_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] ts_low;
	logic [31:0] tagged_word;

	modport source (output valid, ts_low, tagged_word, input ready);
	modport sink (input valid, ts_low, tagged_word, output ready);
endinterface

// ----- rtl/lmeb_out_if.sv -----
// Event channel: valid/ready plus the eight slot fields and the hit mask.
// Depends on nothing.
interface lmeb_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] slow_energy_0;
	logic [15:0] slow_energy_1;
	logic [15:0] fast_energy_0;
	logic [15:0] fast_energy_1;
	logic [63:0] slow_time_0;
	logic [63:0] slow_time_1;
	logic [63:0] fast_time_0;
	logic [63:0] fast_time_1;
	logic [7:0]  hit_mask;

	modport source (output valid, slow_energy_0, slow_energy_1, fast_energy_0,
		fast_energy_1, slow_time_0, slow_time_1, fast_time_0, fast_time_1,
		hit_mask, input ready);
	modport sink (input valid, slow_energy_0, slow_energy_1, fast_energy_0,
		fast_energy_1, slow_time_0, slow_time_1, fast_time_0, fast_time_1,
		hit_mask, output ready);
endinterface

// ----- rtl/lmeb_cfg_if.sv -----
// Configuration write channel for the event window register.
// Depends on nothing.
interface lmeb_cfg_if;
	logic        valid;
	logic        ready;
	logic [27:0] window_ticks;

	modport source (output valid, window_ticks, input ready);
	modport sink (input valid, window_ticks, output ready);
endinterface

// ----- rtl/lmeb_front.sv -----
// Front end: accepts words, drops filler, tracks the timestamp and decides
// event closes. Depends on lmeb_pkg, lmeb_in_if and lmeb_cfg_if.
module lmeb_front import lmeb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	lmeb_in_if.sink  words,
	lmeb_cfg_if.sink cfg,
	output logic     push,
	output lmeb_op_t push_op,
	input  logic     q_full
);

	logic [STAMP_W-1:0]  stamp_q;
	logic [STAMP_W-1:0]  prev_stamp_q;
	logic                wrap_done_q;
	logic [WINDOW_W-1:0] window_q;

	logic [31:0]        low;
	logic [31:0]        word;
	logic               accept;
	logic               filler;
	logic               is_data;
	logic               is_sync;
	logic [11:0]        ident;
	logic [15:0]        value;
	logic [19:0]        upper;
	logic               wrap;
	logic [STAMP_W-1:0] data_stamp;
	logic [STAMP_W-1:0] sync_stamp;
	logic [STAMP_W:0]   diff;
	logic               close;
	logic               hit;
	logic [2:0]         slot;

	assign low    = words.ts_low;
	assign word   = words.tagged_word;
	assign ident  = word[27:16];
	assign value  = word[15:0];

	assign words.ready = !q_full;
	assign accept      = words.valid && words.ready;
	assign cfg.ready   = 1'b1;

	// Classification
	assign filler = (low == 32'd0 && word == 32'd0) ||
		(low == FILL_WORD && (word == FILL_WORD || word == FILL_ONES));
	assign is_data = !filler && word[31:30] == TYPE_DATA && ident[11:5] != EXCLUDED_CARD;
	assign is_sync = !filler && (word & SYNC_MASK) == SYNC_CODE;

	// Timestamp rebuild with one-time wrap correction
	assign upper      = stamp_q[47:28] | {16'd0, low[31:28]};
	assign wrap       = low <= WRAP_LIMIT && !wrap_done_q;
	assign data_stamp = {upper + {19'd0, wrap}, low[27:0]};
	assign sync_stamp = {word[19:0] | {16'd0, low[31:28]}, low[27:0]};

	// Gap test; a borrow means the stamp went backward
	assign diff  = {1'b0, data_stamp} - {1'b0, prev_stamp_q};
	assign close = !diff[STAMP_W] && diff[STAMP_W-1:0] >= {20'd0, window_q};

	// Ident to slot decoder
	always_comb begin
		hit  = 1'b1;
		slot = SLOT_SLOW_E0;
		unique case (ident)
			ID_SLOW_E0: slot = SLOT_SLOW_E0;
			ID_SLOW_E1: slot = SLOT_SLOW_E1;
			ID_FAST_E0: slot = SLOT_FAST_E0;
			ID_FAST_E1: slot = SLOT_FAST_E1;
			ID_SLOW_T0: slot = SLOT_SLOW_T0;
			ID_SLOW_T1: slot = SLOT_SLOW_T1;
			ID_FAST_T0: begin
				slot = SLOT_FAST_T0;
				hit  = value[15:13] != COARSE_BAD;
			end
			ID_FAST_T1: begin
				slot = SLOT_FAST_T1;
				hit  = value[15:13] != COARSE_BAD;
			end
			default: hit = 1'b0;
		endcase
	end

	// Only words that close an event or store a hit go to the back end
	assign push          = accept && is_data && (close || hit);
	assign push_op.close = close;
	assign push_op.hit   = hit;
	assign push_op.slot  = slot;
	assign push_op.value = value;
	assign push_op.stamp = data_stamp;

	// Timestamp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q      <= '0;
			prev_stamp_q <= '0;
			wrap_done_q  <= 1'b0;
		end else if (accept && is_data) begin
			stamp_q      <= data_stamp;
			prev_stamp_q <= data_stamp;
			if (wrap)
				wrap_done_q <= 1'b1;
		end else if (accept && is_sync) begin
			stamp_q     <= sync_stamp;
			wrap_done_q <= 1'b0;
		end
	end

	// Window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_q <= WINDOW_RESET;
		else if (cfg.valid && cfg.ready)
			window_q <= cfg.window_ticks;
	end

endmodule

// ----- rtl/lmeb_queue.sv -----
// Short FIFO of classified words between front and back end.
// Depends on lmeb_pkg.
module lmeb_queue import lmeb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  lmeb_op_t push_op,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output lmeb_op_t head_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lmeb_op_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_op    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_op;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/lmeb_back.sv -----
// Back end: holds the open event's slots, emits events into an output
// register and stores first hits. Depends on lmeb_pkg and lmeb_out_if.
module lmeb_back import lmeb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  lmeb_op_t   head_op,
	output logic       pop,
	lmeb_out_if.source events
);

	logic [ENERGY_W-1:0] energy_q [4];
	logic [TIME_W-1:0]   time_q [4];
	logic [SLOTS-1:0]    filled_q;

	logic                out_valid_q;
	logic [ENERGY_W-1:0] out_energy_q [4];
	logic [TIME_W-1:0]   out_time_q [4];
	logic [SLOTS-1:0]    out_mask_q;

	logic                out_free;
	logic [SLOTS-1:0]    base_filled;
	logic [SLOTS-1:0]    slot_bit;
	logic                write_hit;
	logic [50:0]         stamp_x5;
	logic [50:0]         coarse_sum;
	logic [TIME_W-1:0]   hit_time;

	// A close needs the output register; other words never wait
	assign out_free = !out_valid_q || events.ready;
	assign pop      = head_valid && (!head_op.close || out_free);

	assign base_filled = head_op.close ? '0 : filled_q;
	assign slot_bit    = SLOTS'(1) << head_op.slot;
	assign write_hit   = pop && head_op.hit && !base_filled[head_op.slot];

	// stamp*40960 + coarse*8192 + fine = ((stamp*5 + coarse) << 13) | fine
	assign stamp_x5   = {1'b0, head_op.stamp, 2'b00} + {3'b000, head_op.stamp};
	assign coarse_sum = stamp_x5 + {48'd0, head_op.value[15:13]};
	assign hit_time   = {coarse_sum, head_op.value[12:0]};

	// Open event slots: a close clears them, the word's own hit starts the next event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			for (int k = 0; k < 4; k++) begin
				energy_q[k] <= '0;
				time_q[k]   <= '0;
			end
		end else if (pop) begin
			filled_q <= base_filled | (write_hit ? slot_bit : '0);
			for (int k = 0; k < 4; k++) begin
				if (write_hit && !head_op.slot[2] && head_op.slot[1:0] == 2'(k))
					energy_q[k] <= head_op.value;
				else if (head_op.close)
					energy_q[k] <= '0;
				if (write_hit && head_op.slot[2] && head_op.slot[1:0] == 2'(k))
					time_q[k] <= hit_time;
				else if (head_op.close)
					time_q[k] <= '0;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop && head_op.close)
			out_valid_q <= 1'b1;
		else if (events.ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop && head_op.close) begin
			out_mask_q <= filled_q;
			for (int k = 0; k < 4; k++) begin
				out_energy_q[k] <= energy_q[k];
				out_time_q[k]   <= time_q[k];
			end
		end
	end

	assign events.valid         = out_valid_q;
	assign events.slow_energy_0 = out_energy_q[0];
	assign events.slow_energy_1 = out_energy_q[1];
	assign events.fast_energy_0 = out_energy_q[2];
	assign events.fast_energy_1 = out_energy_q[3];
	assign events.slow_time_0   = out_time_q[0];
	assign events.slow_time_1   = out_time_q[1];
	assign events.fast_time_0   = out_time_q[2];
	assign events.fast_time_1   = out_time_q[3];
	assign events.hit_mask      = out_mask_q;

endmodule

// ----- rtl/list_mode_event_builder.sv -----
// List-mode event builder, top level.
// Channels: words (ts_low + tagged_word in, valid/ready), events (eight slot
// fields + hit_mask out, valid/ready), cfg (window_ticks write, always ready).
// Throughput: one word per cycle while the queue is not full; filler, sync and untracked words
// that close nothing are consumed in the front end and never reach the back end.
// Event path: the word that closes an event is written into the queue when it is
// accepted; at the queue head with the output register free, it loads the event there.
// The closing word's own hit starts the next event.
// The rate is set by the front end's combinational stamp rebuild and gap compare,
// and by the back end retiring one queued word per cycle unless a close is stalled.
// Stall: while the output register holds an event and events.ready is low, a
// closing word waits at the head; DEPTH entries then fill before words.ready drops.
// Reset: window_ticks returns to 90; stamp, previous stamp, wrap flag and
// all slots clear; queue and output register empty.
// Depends on lmeb_pkg, the three channel interfaces and the lmeb_* modules.
module list_mode_event_builder import lmeb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	lmeb_in_if.sink    words,
	lmeb_out_if.source events,
	lmeb_cfg_if.sink   cfg
);

	logic     push;
	lmeb_op_t push_op;
	logic     q_full;
	logic     pop;
	logic     head_valid;
	lmeb_op_t head_op;

	// Classify and time-stamp
	lmeb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.words   (words),
		.cfg     (cfg),
		.push    (push),
		.push_op (push_op),
		.q_full  (q_full)
	);

	// Decoupling queue
	lmeb_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	// Slot store and event output
	lmeb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.events     (events)
	);

endmodule
